// ----- rtl/mf3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int WIDTH_BITS    = 10;
    localparam int HEIGHT_BITS   = 12;
    localparam int CFG_DATA_BITS = 12;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [HEIGHT_BITS-1:0] HEIGHT_LIMIT  = 12'd4094;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET   = 10'd1022;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET  = 12'd766;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_INTERIOR_WIDTH  = 1'b0,
        REG_INTERIOR_HEIGHT = 1'b1
    } mf3_reg_index_t;

    typedef struct packed {
        logic prod;
        logic last;
    } mf3_tag_t;

endpackage

// ----- rtl/mf3_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_line_store
// Line memory holding the two previous rows, one word per column.
// ----------------------------------------------------------------------------
module mf3_line_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    parameter int AW     = 10
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/mf3_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_window
// Chain of three column cells. A new column is sorted as it enters and
// each cell hands its sorted column to its left neighbor on every shift.
// ----------------------------------------------------------------------------
module mf3_window #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  logic [PIXEL_BITS-1:0]      up_px,
    input  logic [PIXEL_BITS-1:0]      mid_px,
    input  logic [PIXEL_BITS-1:0]      new_px,
    output logic [2:0][PIXEL_BITS-1:0] col_lo,
    output logic [2:0][PIXEL_BITS-1:0] col_md,
    output logic [2:0][PIXEL_BITS-1:0] col_hi
);

    logic [PIXEL_BITS-1:0] x0, x1, y1;
    logic [PIXEL_BITS-1:0] sort_lo, sort_md, sort_hi;
    logic [2:0][PIXEL_BITS-1:0] lo_reg, md_reg, hi_reg;

    always_comb begin
        x0      = (up_px < mid_px) ? up_px : mid_px;
        x1      = (up_px < mid_px) ? mid_px : up_px;
        y1      = (x1 < new_px) ? x1 : new_px;
        sort_hi = (x1 < new_px) ? new_px : x1;
        sort_lo = (x0 < y1) ? x0 : y1;
        sort_md = (x0 < y1) ? y1 : x0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            md_reg <= '0;
            hi_reg <= '0;
        end else if (shift_en) begin
            for (int i = 0; i < 2; i++) begin
                lo_reg[i] <= lo_reg[i+1];
                md_reg[i] <= md_reg[i+1];
                hi_reg[i] <= hi_reg[i+1];
            end
            lo_reg[2] <= sort_lo;
            md_reg[2] <= sort_md;
            hi_reg[2] <= sort_hi;
        end
    end

    assign col_lo = lo_reg;
    assign col_md = md_reg;
    assign col_hi = hi_reg;

endmodule

// ----- rtl/mf3_median_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median_merge
// Merges three sorted columns into the median of nine: the largest low,
// the middle mid and the smallest high are registered, then their median
// is formed.
// ----------------------------------------------------------------------------
module mf3_median_merge #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  mf3_pkg::mf3_tag_t          in_tag,
    input  logic [2:0][PIXEL_BITS-1:0] col_lo,
    input  logic [2:0][PIXEL_BITS-1:0] col_md,
    input  logic [2:0][PIXEL_BITS-1:0] col_hi,
    output mf3_pkg::mf3_tag_t          out_tag,
    output logic [PIXEL_BITS-1:0]      median
);

    import mf3_pkg::*;

    mf3_tag_t              tag_reg;
    logic [PIXEL_BITS-1:0] lo_reg, md_reg, hi_reg;

    function automatic logic [PIXEL_BITS-1:0] max3(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic [PIXEL_BITS-1:0] c);
        logic [PIXEL_BITS-1:0] m;
        m = (a < b) ? b : a;
        return (m < c) ? c : m;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] min3(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic [PIXEL_BITS-1:0] c);
        logic [PIXEL_BITS-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] med3(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic [PIXEL_BITS-1:0] c);
        logic [PIXEL_BITS-1:0] mn, mx, t;
        mn = (a < b) ? a : b;
        mx = (a < b) ? b : a;
        t  = (mx < c) ? mx : c;
        return (mn < t) ? t : mn;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= max3(col_lo[0], col_lo[1], col_lo[2]);
            md_reg <= med3(col_md[0], col_md[1], col_md[2]);
            hi_reg <= min3(col_hi[0], col_hi[1], col_hi[2]);
        end
    end

    assign out_tag = tag_reg;
    assign median  = med3(lo_reg, md_reg, hi_reg);

endmodule

// ----- rtl/median_filter_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// 3x3 median filter over a bordered image streamed in raster order.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while s_ready is high, and the frame
// is interior_height + 2 rows of interior_width + 2 pixels, border included.
// Every interior pixel gives one request on the result side after its window
// is sorted and merged, and the last one of a frame carries m_frame_last.
// The rate is set by the line store, which does one read and one write per
// pixel, and by the column cells, which shift once per pixel. Widths above
// MAX_LINE - 2 are treated as MAX_LINE - 2, and heights above 4094 as 4094.
// Frames may follow each other without a reset.
module median_filter_3x3_unit #(
    parameter int MAX_LINE   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [PIXEL_BITS-1:0]               s_pixel_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [PIXEL_BITS-1:0]               m_median_out,
    output logic                                m_frame_last
);

    import mf3_pkg::*;

    localparam int CW   = $clog2(MAX_LINE);
    localparam int CMPW = ((CW > WIDTH_BITS) ? CW : WIDTH_BITS) + 1;
    localparam logic [CMPW-1:0] WIDTH_CAP = CMPW'(MAX_LINE - 2);

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [CW-1:0]          col_reg, col_next;
    logic [HEIGHT_BITS-1:0] row_reg, row_next;

    logic [CMPW-1:0]        width_ext, width_eff;
    logic [CW-1:0]          last_col;
    logic [HEIGHT_BITS-1:0] height_eff, last_row;
    logic                   col_wrap, row_wrap;
    mf3_tag_t               tag_a;

    logic                   adv, accept;
    logic                   valid_b_reg;
    mf3_tag_t               tag_b_reg;
    logic [PIXEL_BITS-1:0]  px_b_reg;
    logic [CW-1:0]          col_b_reg;
    logic [2*PIXEL_BITS-1:0] rd_data;

    mf3_tag_t               tag_c_reg, tag_d;
    logic [2:0][PIXEL_BITS-1:0] col_lo, col_md, col_hi;
    logic [PIXEL_BITS-1:0]  median_d;

    logic                   m_valid_reg;
    logic [PIXEL_BITS-1:0]  median_reg;
    logic                   last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (mf3_reg_index_t'(cfg_index))
                REG_INTERIOR_WIDTH:  width_reg  <= cfg_wr_data[WIDTH_BITS-1:0];
                REG_INTERIOR_HEIGHT: height_reg <= cfg_wr_data[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        width_ext  = CMPW'(width_reg);
        width_eff  = (width_ext > WIDTH_CAP) ? WIDTH_CAP : width_ext;
        last_col   = CW'(width_eff + CMPW'(1));
        height_eff = (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
        last_row   = height_eff + HEIGHT_BITS'(1);
        col_wrap   = (col_reg >= last_col);
        row_wrap   = (row_reg >= last_row);
        tag_a.prod = (row_reg >= HEIGHT_BITS'(2)) && (col_reg >= CW'(2));
        tag_a.last = col_wrap && row_wrap;
        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + HEIGHT_BITS'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    assign adv     = !(tag_d.prod && m_valid_reg && !m_ready);
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
            tag_b_reg   <= '0;
            tag_c_reg   <= '0;
        end else if (adv) begin
            valid_b_reg <= accept;
            tag_b_reg   <= tag_a;
            tag_c_reg.prod <= valid_b_reg && tag_b_reg.prod;
            tag_c_reg.last <= tag_b_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_b_reg  <= s_pixel_in;
            col_b_reg <= col_reg;
        end
    end

    mf3_line_store #(
        .DEPTH  (MAX_LINE),
        .DATA_W (2 * PIXEL_BITS),
        .AW     (CW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (adv && valid_b_reg),
        .wr_addr (col_b_reg),
        .wr_data ({rd_data[PIXEL_BITS-1:0], px_b_reg})
    );

    mf3_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (adv && valid_b_reg),
        .up_px    (rd_data[2*PIXEL_BITS-1:PIXEL_BITS]),
        .mid_px   (rd_data[PIXEL_BITS-1:0]),
        .new_px   (px_b_reg),
        .col_lo   (col_lo),
        .col_md   (col_md),
        .col_hi   (col_hi)
    );

    mf3_median_merge #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_tag  (tag_c_reg),
        .col_lo  (col_lo),
        .col_md  (col_md),
        .col_hi  (col_hi),
        .out_tag (tag_d),
        .median  (median_d)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && tag_d.prod) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tag_d.prod) begin
            median_reg <= median_d;
            last_reg   <= tag_d.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_median_out = median_reg;
    assign m_frame_last = last_reg;

endmodule

// ----- tb/median_filter_3x3_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_unit_tb
// Self-checking bench for the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
// Bordered frames are streamed through the unit while a scoreboard tracks the
// line stores, the window and the frame position to predict every median and
// the end-of-frame flag. The run first fills the line store entries that later
// frames use with one frame at the widest random width, then covers a few
// directed frames and zero-size frames, then many small random frames with
// random stalls on both sides and size changes in the middle of a frame. It
// ends with a small frame streamed without any stalls.
// ----------------------------------------------------------------------------
import mf3_pkg::*;

typedef struct {
    logic [7:0] median;
    logic       last;
} median_result_t;

typedef enum int {
    MIX_UNIFORM,
    MIX_NARROW,
    MIX_EXTREME
} pixel_mix_t;

class median_scoreboard;
    localparam int LINE_DEPTH = 1024;

    logic [7:0]       upper_line [LINE_DEPTH];
    logic [7:0]       middle_line [LINE_DEPTH];
    logic [7:0]       window [9];
    logic [11:0]      row_pos;
    logic [9:0]       col_pos;
    logic [9:0]       width_reg;
    logic [11:0]      height_reg;
    median_result_t   expected_q [$];
    int unsigned      errors;
    int unsigned      pixels_noted;
    int unsigned      medians_checked;
    int unsigned      frame_ends;

    function new();
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        foreach (window[i]) begin
            window[i] = '0;
        end
        row_pos = '0;
        col_pos = '0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        errors = 0;
        pixels_noted = 0;
        medians_checked = 0;
        frame_ends = 0;
    endfunction

    function void set_reg(mf3_reg_index_t idx, logic [11:0] value);
        case (idx)
            REG_INTERIOR_WIDTH: begin
                width_reg = value[9:0];
            end
            REG_INTERIOR_HEIGHT: begin
                height_reg = value;
            end
            default: begin
            end
        endcase
    endfunction

    function logic [9:0] eff_width();
        return (width_reg > 10'(LINE_DEPTH - 2)) ? 10'(LINE_DEPTH - 2) : width_reg;
    endfunction

    function logic [11:0] eff_height();
        return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    endfunction

    function int unsigned frame_pixels();
        return (int'(eff_width()) + 2) * (int'(eff_height()) + 2);
    endfunction

    function bit at_frame_start();
        return (row_pos == 0) && (col_pos == 0);
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function logic [7:0] window_median();
        logic [7:0] v [9];
        logic [7:0] key;
        int         j;
        v = window;
        for (int i = 1; i < 9; i++) begin
            key = v[i];
            j = i;
            while (j > 0 && v[j-1] > key) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = key;
        end
        return v[4];
    endfunction

    function void note_pixel(logic [7:0] px);
        logic [9:0]     last_col;
        logic [11:0]    last_row;
        logic [7:0]     up;
        logic [7:0]     mid;
        bit             col_wrap;
        bit             row_wrap;
        median_result_t res;
        last_col = eff_width() + 10'd1;
        last_row = eff_height() + 12'd1;
        up = upper_line[col_pos];
        mid = middle_line[col_pos];
        upper_line[col_pos] = mid;
        middle_line[col_pos] = px;
        for (int r = 0; r < 3; r++) begin
            window[3*r] = window[3*r+1];
            window[3*r+1] = window[3*r+2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = px;
        col_wrap = col_pos >= last_col;
        row_wrap = row_pos >= last_row;
        if (row_pos >= 2 && col_pos >= 2) begin
            res.median = window_median();
            res.last = col_wrap && row_wrap;
            expected_q.push_back(res);
        end
        if (col_wrap) begin
            col_pos = '0;
            row_pos = row_wrap ? 12'd0 : row_pos + 12'd1;
        end else begin
            col_pos = col_pos + 10'd1;
        end
        pixels_noted++;
    endfunction

    function void check_result(logic [7:0] median, logic last);
        median_result_t exp_res;
        if (expected_q.size() == 0) begin
            $error("unexpected result: median_out %0d, frame_last %0d", median, last);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        medians_checked++;
        if (median !== exp_res.median) begin
            $error("median_out mismatch: expected %0d, actual %0d", exp_res.median, median);
            errors++;
        end
        if (last !== exp_res.last) begin
            $error("frame_last mismatch: expected %0d, actual %0d", exp_res.last, last);
            errors++;
        end
        if (exp_res.last) begin
            frame_ends++;
        end
    endfunction
endclass

module median_filter_3x3_unit_tb;

    logic                             aclk;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]        cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]         cfg_wr_data = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [7:0]                       s_pixel_in = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [7:0]                       m_median_out;
    logic                             m_frame_last;

    median_scoreboard sb;
    bit               calm = 1'b0;
    int unsigned      ready_left = 0;

    median_filter_3x3_unit #(
        .MAX_LINE   (1024),
        .PIXEL_BITS (8)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_median_out (m_median_out),
        .m_frame_last (m_frame_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_median_out, m_frame_last);
        end
        if (calm) begin
            m_ready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready <= 1'b0;
            ready_left <= $urandom_range(0, 9);
        end else begin
            m_ready <= 1'b1;
            ready_left <= $urandom_range(0, 40);
        end
    end

    task automatic write_reg(input mf3_reg_index_t idx, input logic [11:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic write_both(input logic [11:0] width, input logic [11:0] height);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_INTERIOR_WIDTH;
        cfg_wr_data <= width;
        @(posedge aclk);
        cfg_index <= REG_INTERIOR_HEIGHT;
        cfg_wr_data <= height;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(REG_INTERIOR_WIDTH, width);
        sb.set_reg(REG_INTERIOR_HEIGHT, height);
    endtask

    task automatic send_pixel(input logic [7:0] px);
        s_valid <= 1'b1;
        s_pixel_in <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
    endtask

    task automatic stream_pixels(input int unsigned count, input pixel_mix_t mix);
        logic [7:0] px;
        for (int unsigned n = 0; n < count; n++) begin
            if (!calm && $urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            case (mix)
                MIX_NARROW:  px = 8'($urandom_range(100, 103));
                MIX_EXTREME: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:     px = 8'($urandom_range(0, 255));
            endcase
            send_pixel(px);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic finish_frame();
        while (!sb.at_frame_start()) stream_pixels(1, MIX_UNIFORM);
    endtask

    initial begin
        int unsigned width;
        int unsigned height;
        int unsigned count;
        int unsigned random_sent;

        sb = new();
        random_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One frame at the widest random width fills every line store entry in use.
        write_both(12'd64, 12'd1);
        stream_pixels(sb.frame_pixels(), MIX_UNIFORM);
        wait_idle();

        write_both(12'd1, 12'd1);
        for (int i = 0; i < 9; i++) begin
            send_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
        end
        for (int i = 0; i < 9; i++) begin
            send_pixel((i % 2 == 0) ? 8'h00 : 8'hFF);
        end
        wait_idle();
        write_reg(REG_INTERIOR_WIDTH, 12'd0);
        stream_pixels(sb.frame_pixels(), MIX_EXTREME);
        wait_idle();

        while (random_sent < 1500) begin
            case ($urandom_range(0, 9))
                0:       width = 0;
                7, 8:    width = $urandom_range(7, 64);
                default: width = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       height = 0;
                8, 9:    height = $urandom_range(5, 12);
                default: height = $urandom_range(1, 4);
            endcase
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0:       write_reg(REG_INTERIOR_WIDTH, 12'(width));
                1:       write_reg(REG_INTERIOR_HEIGHT, 12'(height));
                default: write_both(12'(width), 12'(height));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, sb.frame_pixels());
            end else begin
                count = sb.frame_pixels() * $urandom_range(1, 2);
            end
            if (count > 1500 - random_sent) begin
                count = 1500 - random_sent;
            end
            stream_pixels(count, pixel_mix_t'($urandom_range(0, 2)));
            random_sent += count;
        end

        calm = 1'b0;
        finish_frame();
        wait_idle();

        calm = 1'b1;
        write_both(12'd6, 12'd4);
        stream_pixels(sb.frame_pixels(), MIX_UNIFORM);
        wait_idle();

        $display("Checked %0d medians from %0d pixels, %0d frame ends seen.",
                 sb.medians_checked, sb.pixels_noted, sb.frame_ends);
        $display("Sizes ranged from zero up to 64 columns and 12 rows, with mid-frame changes.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mf3_pkg.sv
rtl/mf3_line_store.sv
rtl/mf3_window.sv
rtl/mf3_median_merge.sv
rtl/median_filter_3x3_unit.sv
tb/median_filter_3x3_unit_tb.sv
